// ===== hdl/bmhpq_pkg.sv =====
// Package for the binary max-heap priority queue.
// Holds field widths, status and opcode codes, controller states and the
// command/status structs shared between controller and datapath. No dependencies.
package bmhpq_pkg;

	localparam int VAL_W = 32;
	localparam int CNT_W = 9;
	localparam int POS_W = 10;

	localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;
	localparam logic signed [VAL_W-1:0] INT_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP    = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_LAST,
		S_DN_RD,
		S_DN_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic start_ins;
		logic start_pop;
		logic refuse_full;
		logic refuse_empty;
		logic load_last;
		logic up_issue;
		logic up_move;
		logic dn_issue;
		logic dn_move;
		logic place;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_pop;
		logic full;
		logic empty;
		logic pos_root;
		logic up_gt;
		logic leaf;
		logic dn_gt;
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/binary_max_heap_priority_queue_top.sv =====
// Top level of the binary max-heap priority queue.
// Depends on bmhpq_pkg, bmhpq_ctrl, bmhpq_dp (and bmhpq_ram below it).
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------------
//   in      | in_valid / in_stall | op, value
//   out     | out_valid/out_stall | status, popped_value, top_value, entry_count
//   cfg     | cfg_valid/cfg_ready | capacity_limit
//
// An insert rises level by level until it reaches the root or is not above its parent;
// a pop sinks the last entry from the root until it reaches a leaf or no child is greater.
// Each level costs one registered RAM read and one compare-and-write.
// Reset empties the queue and sets the capacity to 256; the store needs no clearing.
// A finished result waits in the output register while the next item is accepted;
// a later item finishing while that register is still stalled holds until it drains.
module binary_max_heap_priority_queue_top #(
	parameter int DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic signed [bmhpq_pkg::VAL_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic signed [bmhpq_pkg::VAL_W-1:0]  popped_value,
	output logic signed [bmhpq_pkg::VAL_W-1:0]  top_value,
	output logic [bmhpq_pkg::CNT_W-1:0]         entry_count,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bmhpq_pkg::CNT_W-1:0]         capacity_limit
);

	bmhpq_pkg::cmd_t cmd;
	bmhpq_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	bmhpq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	bmhpq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (op),
		.value         (value),
		.cfg_valid     (cfg_valid),
		.capacity_limit(capacity_limit),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.popped_value  (popped_value),
		.top_value     (top_value),
		.entry_count   (entry_count)
	);

endmodule

// ===== hdl/bmhpq_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies; contents are undefined until written.
module bmhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== hdl/bmhpq_ctrl.sv =====
// Controller state machine for the heap queue: sequences accept, sift-up,
// sift-down and result hand-off. Depends on bmhpq_pkg.
module bmhpq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  bmhpq_pkg::sts_t sts,
	output bmhpq_pkg::cmd_t cmd
);

	bmhpq_pkg::state_t state_q;
	bmhpq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmhpq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bmhpq_pkg::S_IDLE: begin
				if (in_valid) begin
					if (sts.is_pop) begin
						state_d = sts.empty ? bmhpq_pkg::S_DONE : bmhpq_pkg::S_DN_LAST;
					end else begin
						state_d = sts.full ? bmhpq_pkg::S_DONE : bmhpq_pkg::S_UP_RD;
					end
				end
			end
			bmhpq_pkg::S_UP_RD: begin
				state_d = sts.pos_root ? bmhpq_pkg::S_DONE : bmhpq_pkg::S_UP_CMP;
			end
			bmhpq_pkg::S_UP_CMP: begin
				state_d = sts.up_gt ? bmhpq_pkg::S_UP_RD : bmhpq_pkg::S_DONE;
			end
			bmhpq_pkg::S_DN_LAST: begin
				state_d = bmhpq_pkg::S_DN_RD;
			end
			bmhpq_pkg::S_DN_RD: begin
				state_d = sts.leaf ? bmhpq_pkg::S_DONE : bmhpq_pkg::S_DN_CMP;
			end
			bmhpq_pkg::S_DN_CMP: begin
				state_d = sts.dn_gt ? bmhpq_pkg::S_DN_RD : bmhpq_pkg::S_DONE;
			end
			bmhpq_pkg::S_DONE: begin
				if (sts.out_free) begin
					state_d = bmhpq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bmhpq_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			bmhpq_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (sts.is_pop) begin
						cmd.refuse_empty = sts.empty;
						cmd.start_pop    = !sts.empty;
					end else begin
						cmd.refuse_full = sts.full;
						cmd.start_ins   = !sts.full;
					end
				end
			end
			bmhpq_pkg::S_UP_RD: begin
				cmd.place    = sts.pos_root;
				cmd.up_issue = !sts.pos_root;
			end
			bmhpq_pkg::S_UP_CMP: begin
				cmd.up_move = sts.up_gt;
				cmd.place   = !sts.up_gt;
			end
			bmhpq_pkg::S_DN_LAST: begin
				cmd.load_last = 1'b1;
			end
			bmhpq_pkg::S_DN_RD: begin
				cmd.place    = sts.leaf;
				cmd.dn_issue = !sts.leaf;
			end
			bmhpq_pkg::S_DN_CMP: begin
				cmd.dn_move = sts.dn_gt;
				cmd.place   = !sts.dn_gt;
			end
			bmhpq_pkg::S_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== hdl/bmhpq_dp.sv =====
// Datapath for the heap queue: heap RAM, count, moving entry and hole position,
// cached root, capacity register and result register. Depends on bmhpq_pkg, bmhpq_ram.
module bmhpq_dp #(
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bmhpq_pkg::cmd_t                       cmd,
	output bmhpq_pkg::sts_t                       sts,
	input  logic                                  op,
	input  logic signed [bmhpq_pkg::VAL_W-1:0]    value,
	input  logic                                  cfg_valid,
	input  logic [bmhpq_pkg::CNT_W-1:0]           capacity_limit,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [1:0]                            status,
	output logic signed [bmhpq_pkg::VAL_W-1:0]    popped_value,
	output logic signed [bmhpq_pkg::VAL_W-1:0]    top_value,
	output logic [bmhpq_pkg::CNT_W-1:0]           entry_count
);

	localparam int AW     = $clog2(DEPTH);
	localparam int CapTop = (DEPTH < 511) ? DEPTH : 511;

	logic [bmhpq_pkg::CNT_W-1:0]        count_q;
	logic [bmhpq_pkg::CNT_W-1:0]        cap_q;
	logic [bmhpq_pkg::CNT_W-1:0]        pos_q;
	logic signed [bmhpq_pkg::VAL_W-1:0] v_q;
	logic signed [bmhpq_pkg::VAL_W-1:0] top_q;
	logic signed [bmhpq_pkg::VAL_W-1:0] popped_q;
	bmhpq_pkg::status_t                 status_q;

	logic                               out_valid_q;
	bmhpq_pkg::status_t                 out_status_q;
	logic signed [bmhpq_pkg::VAL_W-1:0] out_popped_q;
	logic signed [bmhpq_pkg::VAL_W-1:0] out_top_q;
	logic [bmhpq_pkg::CNT_W-1:0]        out_count_q;

	logic [bmhpq_pkg::CNT_W-1:0]        cap_eff;
	logic [bmhpq_pkg::CNT_W-1:0]        parent;
	logic [bmhpq_pkg::POS_W-1:0]        left;
	logic [bmhpq_pkg::POS_W-1:0]        right;
	logic                               right_ok;
	logic                               pick_right;
	logic signed [bmhpq_pkg::VAL_W-1:0] child;
	logic [bmhpq_pkg::CNT_W-1:0]        child_pos;

	logic                               we;
	logic [AW-1:0]                      waddr;
	logic signed [bmhpq_pkg::VAL_W-1:0] wdata;
	logic [AW-1:0]                      raddr_a;
	logic [AW-1:0]                      raddr_b;
	logic signed [bmhpq_pkg::VAL_W-1:0] rdata_a;
	logic signed [bmhpq_pkg::VAL_W-1:0] rdata_b;

	// effective capacity never exceeds the store
	assign cap_eff = (cap_q > bmhpq_pkg::CNT_W'(CapTop)) ? bmhpq_pkg::CNT_W'(CapTop) : cap_q;

	assign parent     = pos_q >> 1;
	assign left       = {pos_q, 1'b0};
	assign right      = {pos_q, 1'b1};
	assign right_ok   = right <= {1'b0, count_q};
	// left child wins a tie
	assign pick_right = right_ok && (rdata_b > rdata_a);
	assign child      = pick_right ? rdata_b : rdata_a;
	assign child_pos  = pick_right ? right[bmhpq_pkg::CNT_W-1:0] : left[bmhpq_pkg::CNT_W-1:0];

	assign sts.is_pop   = (op == bmhpq_pkg::OP_POP);
	assign sts.full     = count_q >= cap_eff;
	assign sts.empty    = (count_q == '0);
	assign sts.pos_root = (pos_q == bmhpq_pkg::CNT_W'(1));
	assign sts.up_gt    = v_q > rdata_a;
	assign sts.leaf     = left > {1'b0, count_q};
	assign sts.dn_gt    = child > v_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	// the moving entry lives in v_q; the hole at pos_q takes either it or a shifted entry
	assign we    = cmd.place || cmd.up_move || cmd.dn_move;
	assign waddr = AW'(pos_q - bmhpq_pkg::CNT_W'(1));
	assign wdata = cmd.place ? v_q : (cmd.up_move ? rdata_a : child);

	always_comb begin
		if (cmd.up_issue) begin
			raddr_a = AW'(parent - bmhpq_pkg::CNT_W'(1));
		end else if (cmd.dn_issue) begin
			raddr_a = AW'(left - bmhpq_pkg::POS_W'(1));
		end else begin
			// last entry, for a pop about to be accepted
			raddr_a = AW'(count_q - bmhpq_pkg::CNT_W'(1));
		end
	end
	assign raddr_b = AW'(left);

	bmhpq_ram #(
		.WIDTH(bmhpq_pkg::VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= bmhpq_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= capacity_limit;
			end
			if (cmd.start_ins) begin
				count_q <= count_q + bmhpq_pkg::CNT_W'(1);
			end else if (cmd.start_pop) begin
				count_q <= count_q - bmhpq_pkg::CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_ins) begin
			pos_q    <= count_q + bmhpq_pkg::CNT_W'(1);
			v_q      <= value;
			status_q <= bmhpq_pkg::ST_OK;
			popped_q <= bmhpq_pkg::INT_MIN;
		end
		if (cmd.start_pop) begin
			pos_q    <= bmhpq_pkg::CNT_W'(1);
			status_q <= bmhpq_pkg::ST_OK;
			popped_q <= top_q;
		end
		if (cmd.refuse_full) begin
			status_q <= bmhpq_pkg::ST_FULL;
			popped_q <= bmhpq_pkg::INT_MIN;
		end
		if (cmd.refuse_empty) begin
			status_q <= bmhpq_pkg::ST_EMPTY;
			popped_q <= bmhpq_pkg::INT_MIN;
		end
		if (cmd.load_last) begin
			v_q <= rdata_a;
		end
		if (cmd.up_move) begin
			pos_q <= parent;
		end
		if (cmd.dn_move) begin
			pos_q <= child_pos;
		end
		// mirror every root write so the maximum is always at hand
		if (we && sts.pos_root) begin
			top_q <= wdata;
		end
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_popped_q <= popped_q;
			out_top_q    <= (count_q == '0) ? bmhpq_pkg::INT_MIN : top_q;
			out_count_q  <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign popped_value = out_popped_q;
	assign top_value    = out_top_q;
	assign entry_count  = out_count_q;

endmodule

// ===== hdl/bmhpq_chk.sv =====
// Port-level checker for the heap queue, bound to the top level.
// Depends on bmhpq_pkg and binary_max_heap_priority_queue_top.
module bmhpq_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [1:0]                          status,
	input logic signed [bmhpq_pkg::VAL_W-1:0]  popped_value,
	input logic signed [bmhpq_pkg::VAL_W-1:0]  top_value,
	input logic [bmhpq_pkg::CNT_W-1:0]         entry_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_refused_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != bmhpq_pkg::ST_OK) |-> popped_value == bmhpq_pkg::INT_MIN)
		else $error("refused item carries a popped value");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (entry_count == '0) |-> top_value == bmhpq_pkg::INT_MIN)
		else $error("empty queue reports a maximum");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == bmhpq_pkg::ST_EMPTY) |-> entry_count == '0)
		else $error("empty refusal with entries held");

	a_pop_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == bmhpq_pkg::ST_OK) && (popped_value != bmhpq_pkg::INT_MIN)
		|-> popped_value >= top_value)
		else $error("popped value below remaining maximum");

endmodule

bind binary_max_heap_priority_queue_top bmhpq_chk u_bmhpq_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.popped_value(popped_value),
	.top_value   (top_value),
	.entry_count (entry_count)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for binary_max_heap_priority_queue_top: a directed table, then random phases,
// checked against an in-bench heap predictor. Depends on bmhpq_pkg and the RTL under hdl.
module tb_top;

	localparam int HEAP_DEPTH   = 256;
	localparam int CLK_HALF     = 5;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam logic signed [bmhpq_pkg::VAL_W-1:0] INT_MAX = 32'sh7fff_ffff;

	typedef struct {
		bmhpq_pkg::status_t                  st;
		logic signed [bmhpq_pkg::VAL_W-1:0]  popped;
		logic signed [bmhpq_pkg::VAL_W-1:0]  top;
		logic [bmhpq_pkg::CNT_W-1:0]         cnt;
	} heap_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                           kind;
		bmhpq_pkg::op_t                      op;
		logic signed [bmhpq_pkg::VAL_W-1:0]  arg;
		logic                                typed_in;
		heap_result_t                        want;
	} plan_row_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic                                op = 1'b0;
	logic signed [bmhpq_pkg::VAL_W-1:0]  value = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic [1:0]                          status;
	logic signed [bmhpq_pkg::VAL_W-1:0]  popped_value;
	logic signed [bmhpq_pkg::VAL_W-1:0]  top_value;
	logic [bmhpq_pkg::CNT_W-1:0]         entry_count;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [bmhpq_pkg::CNT_W-1:0]         capacity_limit = '0;

	// predictor state: 1-based heap, entry count and capacity register
	logic signed [bmhpq_pkg::VAL_W-1:0]  model_heap [1:HEAP_DEPTH];
	int                                  model_count = 0;
	int                                  model_cap = bmhpq_pkg::CAP_RESET;

	heap_result_t             expected_results [$];
	int                       mismatches = 0;
	int unsigned              cycle_count = 0;
	bit                       no_gaps = 1'b0;
	bit                       hold_req = 1'b0;

	binary_max_heap_priority_queue_top #(.DEPTH(HEAP_DEPTH)) uut (
		.clk, .arst_n,
		.in_valid, .in_stall, .op, .value,
		.out_valid, .out_stall, .status, .popped_value, .top_value, .entry_count,
		.cfg_valid, .cfg_ready, .capacity_limit
	);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	function automatic heap_result_t heap_step(bmhpq_pkg::op_t o,
			logic signed [bmhpq_pkg::VAL_W-1:0] v);
		heap_result_t                        r;
		int                                  lim;
		int                                  pos;
		int                                  par;
		int                                  lc;
		int                                  rc;
		int                                  best;
		logic signed [bmhpq_pkg::VAL_W-1:0]  t;
		lim = (model_cap < HEAP_DEPTH) ? model_cap : HEAP_DEPTH;
		r.st = bmhpq_pkg::ST_OK;
		r.popped = bmhpq_pkg::INT_MIN;
		if (o == bmhpq_pkg::OP_INSERT) begin
			if (model_count >= lim) begin
				r.st = bmhpq_pkg::ST_FULL;
			end else begin
				model_count++;
				pos = model_count;
				model_heap[pos] = v;
				// rise only while strictly greater than the parent
				while (pos > 1) begin
					par = pos / 2;
					if (!(model_heap[pos] > model_heap[par]))
						break;
					t = model_heap[pos];
					model_heap[pos] = model_heap[par];
					model_heap[par] = t;
					pos = par;
				end
			end
		end else if (model_count == 0) begin
			r.st = bmhpq_pkg::ST_EMPTY;
		end else begin
			r.popped = model_heap[1];
			model_heap[1] = model_heap[model_count];
			model_count--;
			pos = 1;
			// sink toward the larger child, left child on a tie
			forever begin
				best = pos;
				lc = 2 * pos;
				rc = lc + 1;
				if (lc <= model_count && model_heap[lc] > model_heap[best])
					best = lc;
				if (rc <= model_count && model_heap[rc] > model_heap[best])
					best = rc;
				if (best == pos)
					break;
				t = model_heap[pos];
				model_heap[pos] = model_heap[best];
				model_heap[best] = t;
				pos = best;
			end
		end
		r.top = (model_count == 0) ? bmhpq_pkg::INT_MIN : model_heap[1];
		r.cnt = model_count[bmhpq_pkg::CNT_W-1:0];
		return r;
	endfunction

	function automatic logic signed [bmhpq_pkg::VAL_W-1:0] draw_value();
		case ($urandom_range(0, 7))
			0: return bmhpq_pkg::INT_MIN;
			1: return INT_MAX;
			2, 3: return $urandom_range(0, 8) - 4;
			default: return $urandom;
		endcase
	endfunction

	function automatic plan_row_t item_row(bmhpq_pkg::op_t o,
			logic signed [bmhpq_pkg::VAL_W-1:0] v);
		plan_row_t row;
		row.kind = ROW_ITEM;
		row.op = o;
		row.arg = v;
		row.typed_in = 1'b0;
		return row;
	endfunction

	function automatic plan_row_t known_row(bmhpq_pkg::op_t o,
			logic signed [bmhpq_pkg::VAL_W-1:0] v, bmhpq_pkg::status_t st,
			logic signed [bmhpq_pkg::VAL_W-1:0] popped,
			logic signed [bmhpq_pkg::VAL_W-1:0] top, int cnt);
		plan_row_t row;
		row = item_row(o, v);
		row.typed_in = 1'b1;
		row.want.st = st;
		row.want.popped = popped;
		row.want.top = top;
		row.want.cnt = cnt[bmhpq_pkg::CNT_W-1:0];
		return row;
	endfunction

	function automatic plan_row_t cap_row(int cap);
		plan_row_t row;
		row.kind = ROW_CFG;
		row.op = bmhpq_pkg::OP_INSERT;
		row.arg = cap;
		row.typed_in = 1'b0;
		return row;
	endfunction

	task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// enter and leave at a falling edge; valid stays high when the next item follows at once
	task automatic offer_item(bmhpq_pkg::op_t o, logic signed [bmhpq_pkg::VAL_W-1:0] v,
			logic typed_in, heap_result_t typed_res);
		int           gap;
		heap_result_t predicted;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		value <= v;
		do @(posedge clk); while (in_stall);
		predicted = heap_step(o, v);
		if (typed_in)
			expected_results.push_back(typed_res);
		else
			expected_results.push_back(predicted);
		@(negedge clk);
	endtask

	task automatic write_capacity(int cap);
		in_valid <= 1'b0;
		// write only once every pending result has drained
		while (expected_results.size() != 0) @(negedge clk);
		cfg_valid <= 1'b1;
		capacity_limit <= cap[bmhpq_pkg::CNT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		model_cap = cap[bmhpq_pkg::CNT_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(int cap, int items, int ins_pct, bit narrow, bit calm, int hold_at);
		bmhpq_pkg::op_t                      o;
		logic signed [bmhpq_pkg::VAL_W-1:0]  v;
		heap_result_t                        no_typed;
		write_capacity(cap);
		no_gaps = calm;
		for (int n = 0; n < items; n++) begin
			o = ($urandom_range(0, 99) < ins_pct) ? bmhpq_pkg::OP_INSERT : bmhpq_pkg::OP_POP;
			v = narrow ? ($urandom_range(0, 8) - 4) : draw_value();
			if (n == hold_at)
				hold_req = 1'b1;
			offer_item(o, v, 1'b0, no_typed);
		end
	endtask

	// result side: random stall per item, a long hold on request
	initial begin
		int           wait_cycles;
		heap_result_t want;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				wait_cycles = LONG_HOLD;
			end else begin
				wait_cycles = no_gaps ? 0 : $urandom_range(0, 9);
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (expected_results.size() == 0) begin
				$display("%0t: result with no item pending, expected none actual status %0d",
					$time, status);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", want.st, status);
				check_field("popped_value", want.popped, popped_value);
				check_field("top_value", want.top, top_value);
				check_field("entry_count", want.cnt, entry_count);
			end
		end
	end

	initial begin
		plan_row_t plan [$];
		plan.push_back(known_row(bmhpq_pkg::OP_POP, 0, bmhpq_pkg::ST_EMPTY,
			bmhpq_pkg::INT_MIN, bmhpq_pkg::INT_MIN, 0));
		plan.push_back(known_row(bmhpq_pkg::OP_INSERT, bmhpq_pkg::INT_MIN, bmhpq_pkg::ST_OK,
			bmhpq_pkg::INT_MIN, bmhpq_pkg::INT_MIN, 1));
		plan.push_back(known_row(bmhpq_pkg::OP_INSERT, INT_MAX, bmhpq_pkg::ST_OK,
			bmhpq_pkg::INT_MIN, INT_MAX, 2));
		plan.push_back(item_row(bmhpq_pkg::OP_INSERT, 0));
		plan.push_back(item_row(bmhpq_pkg::OP_INSERT, -1));
		// equal entries must never swap
		plan.push_back(item_row(bmhpq_pkg::OP_INSERT, 5));
		plan.push_back(item_row(bmhpq_pkg::OP_INSERT, 5));
		plan.push_back(item_row(bmhpq_pkg::OP_INSERT, 5));
		plan.push_back(known_row(bmhpq_pkg::OP_POP, -1, bmhpq_pkg::ST_OK, INT_MAX, 5, 6));
		repeat (6) plan.push_back(item_row(bmhpq_pkg::OP_POP, 32'sh7fff_ffff));
		plan.push_back(known_row(bmhpq_pkg::OP_POP, 0, bmhpq_pkg::ST_EMPTY,
			bmhpq_pkg::INT_MIN, bmhpq_pkg::INT_MIN, 0));
		plan.push_back(cap_row(1));
		plan.push_back(known_row(bmhpq_pkg::OP_INSERT, 7, bmhpq_pkg::ST_OK,
			bmhpq_pkg::INT_MIN, 7, 1));
		plan.push_back(known_row(bmhpq_pkg::OP_INSERT, 9, bmhpq_pkg::ST_FULL,
			bmhpq_pkg::INT_MIN, 7, 1));
		// zero capacity refuses every insert, pops still drain
		plan.push_back(cap_row(0));
		plan.push_back(known_row(bmhpq_pkg::OP_INSERT, 3, bmhpq_pkg::ST_FULL,
			bmhpq_pkg::INT_MIN, 7, 1));
		plan.push_back(known_row(bmhpq_pkg::OP_POP, 0, bmhpq_pkg::ST_OK, 7,
			bmhpq_pkg::INT_MIN, 0));
		plan.push_back(known_row(bmhpq_pkg::OP_INSERT, 1, bmhpq_pkg::ST_FULL,
			bmhpq_pkg::INT_MIN, bmhpq_pkg::INT_MIN, 0));
		// above the depth the capacity clamps to the depth
		plan.push_back(cap_row(511));
		plan.push_back(known_row(bmhpq_pkg::OP_INSERT, 32'sh5555_5555, bmhpq_pkg::ST_OK,
			bmhpq_pkg::INT_MIN, 32'sh5555_5555, 1));
		plan.push_back(item_row(bmhpq_pkg::OP_INSERT, 32'shaaaa_aaaa));
		plan.push_back(known_row(bmhpq_pkg::OP_POP, 0, bmhpq_pkg::ST_OK, 32'sh5555_5555,
			32'shaaaa_aaaa, 1));
		plan.push_back(item_row(bmhpq_pkg::OP_POP, -1));

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_capacity(plan[i].arg);
			else
				offer_item(plan[i].op, plan[i].arg, plan[i].typed_in, plan[i].want);
		end

		// fill to the full depth, with the output held off once along the way
		run_phase(HEAP_DEPTH, 340, 90, 1'b0, 1'b0, 150);
		// capacity now below the count
		run_phase(100, 300, 40, 1'b0, 1'b0, -1);
		run_phase(511, 300, 55, 1'b1, 1'b1, -1);
		run_phase($urandom_range(1, HEAP_DEPTH), 300, 60, 1'b0, 1'b0, -1);
		run_phase(0, 60, 50, 1'b0, 1'b0, -1);
		run_phase(2, 100, 50, 1'b1, 1'b1, -1);
		run_phase(HEAP_DEPTH, 300, 30, 1'b0, 1'b0, -1);

		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
